>>> design/rrd_pkg.sv
// Shared types and constants for the request deframer.
// Used by rrd_parse and resp_request_deframer_core; depends on nothing.
`timescale 1ns / 1ps

package rrd_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int ARG_NUM_W = 10;

    // Framing characters
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE   = 8'h39;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
    localparam logic [KIND_W-1:0] KIND_END  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

    typedef enum logic [11:0] {
        PH_EXPECT_STAR   = 12'b0000_0000_0001,
        PH_DISCARD       = 12'b0000_0000_0010,
        PH_COUNT_FIRST   = 12'b0000_0000_0100,
        PH_COUNT_MORE    = 12'b0000_0000_1000,
        PH_COUNT_LF      = 12'b0000_0001_0000,
        PH_EXPECT_DOLLAR = 12'b0000_0010_0000,
        PH_LEN_FIRST     = 12'b0000_0100_0000,
        PH_LEN_MORE      = 12'b0000_1000_0000,
        PH_LEN_LF        = 12'b0001_0000_0000,
        PH_PAYLOAD       = 12'b0010_0000_0000,
        PH_DATA_CR       = 12'b0100_0000_0000,
        PH_DATA_LF       = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        logic                 valid;
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    data;
        logic [ARG_NUM_W-1:0] arg;
        logic                 done;
    } rrd_result_t;

endpackage

>>> design/rrd_parse.sv
// Next-state and result logic of the request deframer for one byte.
// Depends on rrd_pkg; instantiated by resp_request_deframer_core.
`timescale 1ns / 1ps

module rrd_parse #(
    parameter int MAX_ARGS     = 1024,
    parameter int MAX_BULK_LEN = 536870912,
    localparam int MAX_LIM     = (MAX_ARGS > MAX_BULK_LEN) ? MAX_ARGS : MAX_BULK_LEN,
    localparam int ACC_W       = $clog2(MAX_LIM + 1),
    localparam int ARG_W       = $clog2(MAX_ARGS + 1),
    localparam int LEN_W       = $clog2(MAX_BULK_LEN + 1)
) (
    input  logic [rrd_pkg::BYTE_W-1:0]    byte_in,
    input  rrd_pkg::phase_t               phase,
    input  logic [ARG_W-1:0]              args_rem,
    input  logic [LEN_W-1:0]              bytes_rem,
    input  logic [rrd_pkg::ARG_NUM_W-1:0] cur_arg,
    input  logic [ACC_W-1:0]              accum,
    output rrd_pkg::phase_t               phase_next,
    output logic [ARG_W-1:0]              args_rem_next,
    output logic [LEN_W-1:0]              bytes_rem_next,
    output logic [rrd_pkg::ARG_NUM_W-1:0] cur_arg_next,
    output logic [ACC_W-1:0]              accum_next,
    output rrd_pkg::rrd_result_t          res
);

    localparam int SUM_W = ACC_W + 4;
    localparam logic [SUM_W-1:0] CNT_LIM = SUM_W'(MAX_ARGS);
    localparam logic [SUM_W-1:0] LEN_LIM = SUM_W'(MAX_BULK_LEN);

    logic             is_digit;
    logic [SUM_W-1:0] digit_sum;
    logic             cnt_ok;
    logic             len_ok;

    // accum * 10 + digit
    assign is_digit  = (byte_in >= rrd_pkg::CH_ZERO) && (byte_in <= rrd_pkg::CH_NINE);
    assign digit_sum = {1'b0, accum, 3'b000} + {3'b000, accum, 1'b0}
                     + SUM_W'(byte_in[3:0]);
    assign cnt_ok    = is_digit && (digit_sum <= CNT_LIM);
    assign len_ok    = is_digit && (digit_sum <= LEN_LIM);

    always_comb
    begin
        logic do_fail;
        logic do_start;
        do_fail        = 1'b0;
        do_start       = 1'b0;
        phase_next     = phase;
        args_rem_next  = args_rem;
        bytes_rem_next = bytes_rem;
        cur_arg_next   = cur_arg;
        accum_next     = accum;
        res            = '0;
        res.arg        = cur_arg;

        unique case (phase)
            rrd_pkg::PH_EXPECT_STAR:
            begin
                if (byte_in == rrd_pkg::CH_STAR) do_start = 1'b1;
                else                             do_fail  = 1'b1;
            end
            rrd_pkg::PH_COUNT_FIRST:
            begin
                if (cnt_ok)
                begin
                    accum_next = ACC_W'(digit_sum);
                    phase_next = rrd_pkg::PH_COUNT_MORE;
                end
                else
                    do_fail = 1'b1;
            end
            rrd_pkg::PH_COUNT_MORE:
            begin
                if (is_digit)
                begin
                    if (cnt_ok) accum_next = ACC_W'(digit_sum);
                    else        do_fail    = 1'b1;
                end
                else if (byte_in == rrd_pkg::CH_CR && accum != '0)
                    phase_next = rrd_pkg::PH_COUNT_LF;
                else
                    do_fail = 1'b1;
            end
            rrd_pkg::PH_COUNT_LF:
            begin
                if (byte_in == rrd_pkg::CH_LF)
                begin
                    args_rem_next = ARG_W'(accum);
                    cur_arg_next  = '0;
                    phase_next    = rrd_pkg::PH_EXPECT_DOLLAR;
                end
                else
                    do_fail = 1'b1;
            end
            rrd_pkg::PH_EXPECT_DOLLAR:
            begin
                if (byte_in == rrd_pkg::CH_DOLLAR)
                begin
                    accum_next = '0;
                    phase_next = rrd_pkg::PH_LEN_FIRST;
                end
                else
                    do_fail = 1'b1;
            end
            rrd_pkg::PH_LEN_FIRST:
            begin
                if (len_ok)
                begin
                    accum_next = ACC_W'(digit_sum);
                    phase_next = rrd_pkg::PH_LEN_MORE;
                end
                else
                    do_fail = 1'b1;
            end
            rrd_pkg::PH_LEN_MORE:
            begin
                if (is_digit)
                begin
                    if (len_ok) accum_next = ACC_W'(digit_sum);
                    else        do_fail    = 1'b1;
                end
                else if (byte_in == rrd_pkg::CH_CR)
                    phase_next = rrd_pkg::PH_LEN_LF;
                else
                    do_fail = 1'b1;
            end
            rrd_pkg::PH_LEN_LF:
            begin
                if (byte_in == rrd_pkg::CH_LF)
                begin
                    bytes_rem_next = LEN_W'(accum);
                    phase_next     = (accum == '0) ? rrd_pkg::PH_DATA_CR
                                                   : rrd_pkg::PH_PAYLOAD;
                end
                else
                    do_fail = 1'b1;
            end
            rrd_pkg::PH_PAYLOAD:
            begin
                if (bytes_rem != '0) bytes_rem_next = bytes_rem - LEN_W'(1);
                if (bytes_rem <= LEN_W'(1)) phase_next = rrd_pkg::PH_DATA_CR;
                res.valid = 1'b1;
                res.kind  = rrd_pkg::KIND_DATA;
                res.data  = byte_in;
            end
            rrd_pkg::PH_DATA_CR:
            begin
                if (byte_in == rrd_pkg::CH_CR) phase_next = rrd_pkg::PH_DATA_LF;
                else                           do_fail    = 1'b1;
            end
            rrd_pkg::PH_DATA_LF:
            begin
                if (byte_in == rrd_pkg::CH_LF)
                begin
                    res.valid = 1'b1;
                    res.kind  = rrd_pkg::KIND_END;
                    if (args_rem <= ARG_W'(1))
                    begin
                        res.done      = 1'b1;
                        args_rem_next = '0;
                        cur_arg_next  = '0;
                        phase_next    = rrd_pkg::PH_EXPECT_STAR;
                    end
                    else
                    begin
                        args_rem_next = args_rem - ARG_W'(1);
                        cur_arg_next  = cur_arg + rrd_pkg::ARG_NUM_W'(1);
                        phase_next    = rrd_pkg::PH_EXPECT_DOLLAR;
                    end
                end
                else
                    do_fail = 1'b1;
            end
            default:
            begin
                // discarding, and any corrupt code: wait for the next '*'
                if (byte_in == rrd_pkg::CH_STAR) do_start = 1'b1;
            end
        endcase

        if (do_start)
        begin
            phase_next     = rrd_pkg::PH_COUNT_FIRST;
            accum_next     = '0;
            args_rem_next  = '0;
            bytes_rem_next = '0;
            cur_arg_next   = '0;
        end

        if (do_fail)
        begin
            res.valid      = 1'b1;
            res.kind       = rrd_pkg::KIND_ERR;
            res.data       = '0;
            res.done       = 1'b0;
            phase_next     = rrd_pkg::PH_DISCARD;
            accum_next     = '0;
            args_rem_next  = '0;
            bytes_rem_next = '0;
            cur_arg_next   = '0;
        end
    end

endmodule

>>> design/resp_request_deframer_core.sv
// Top level of the multibulk request deframer: input register, parser state, result register.
// Depends on rrd_pkg and rrd_parse.
`timescale 1ns / 1ps

// Usage
// -----
// Input channel (in_valid / in_stall / in_byte) carries the raw request stream, one
// byte per transaction. Requests are '*' count CRLF followed by count arguments of
// the form '$' length CRLF payload CRLF.
// Output channel (out_valid / out_stall and the result fields) carries at most one
// result per input byte: a payload byte with its argument number, an end-of-argument
// marker (request_done set on the last one) or a protocol error. After an error the
// block drops bytes silently until the next '*'.
// Path: an accepted byte sits in the input register while the parser works on it, and
// its result is then loaded into the result register.
// Throughput: one byte per cycle unless out_stall holds up a result; the parser is a
// single pass of compare, multiply-by-ten-and-add and counter logic between the registers.
// Stall: while out_stall holds a result, bytes that yield no result still advance;
// the first byte that would yield one waits in the input register and in_stall rises.
// Reset: rst_n clears all control state; the parser waits for '*'.

module resp_request_deframer_core #(
    parameter int MAX_ARGS     = 1024,
    parameter int MAX_BULK_LEN = 536870912
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rrd_pkg::BYTE_W-1:0]    in_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rrd_pkg::KIND_W-1:0]    kind,
    output logic [rrd_pkg::BYTE_W-1:0]    payload_byte,
    output logic [rrd_pkg::ARG_NUM_W-1:0] arg_number,
    output logic                          request_done
);

    localparam int MAX_LIM = (MAX_ARGS > MAX_BULK_LEN) ? MAX_ARGS : MAX_BULK_LEN;
    localparam int ACC_W   = $clog2(MAX_LIM + 1);
    localparam int ARG_W   = $clog2(MAX_ARGS + 1);
    localparam int LEN_W   = $clog2(MAX_BULK_LEN + 1);

    // input register
    logic                          in_valid_reg;
    logic [rrd_pkg::BYTE_W-1:0]    in_byte_reg;

    // parser state
    rrd_pkg::phase_t               phase_reg,     phase_next;
    logic [ARG_W-1:0]              args_rem_reg,  args_rem_next;
    logic [LEN_W-1:0]              bytes_rem_reg, bytes_rem_next;
    logic [rrd_pkg::ARG_NUM_W-1:0] cur_arg_reg,   cur_arg_next;
    logic [ACC_W-1:0]              accum_reg,     accum_next;

    // result register
    logic                          out_valid_reg;
    logic [rrd_pkg::KIND_W-1:0]    kind_reg;
    logic [rrd_pkg::BYTE_W-1:0]    data_reg;
    logic [rrd_pkg::ARG_NUM_W-1:0] arg_reg;
    logic                          done_reg;

    rrd_pkg::rrd_result_t          res;
    logic                          out_free;
    logic                          step;

    rrd_parse #(
        .MAX_ARGS     (MAX_ARGS),
        .MAX_BULK_LEN (MAX_BULK_LEN)
    ) u_parse (
        .byte_in        (in_byte_reg),
        .phase          (phase_reg),
        .args_rem       (args_rem_reg),
        .bytes_rem      (bytes_rem_reg),
        .cur_arg        (cur_arg_reg),
        .accum          (accum_reg),
        .phase_next     (phase_next),
        .args_rem_next  (args_rem_next),
        .bytes_rem_next (bytes_rem_next),
        .cur_arg_next   (cur_arg_next),
        .accum_next     (accum_next),
        .res            (res)
    );

    // The result register can take a new entry if empty or being drained now.
    assign out_free = !out_valid_reg || !out_stall;
    // Advance the held byte unless it makes a result that has nowhere to go.
    assign step     = in_valid_reg && (!res.valid || out_free);
    assign in_stall = in_valid_reg && !step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_byte_reg <= in_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rrd_pkg::PH_EXPECT_STAR;
            args_rem_reg  <= '0;
            bytes_rem_reg <= '0;
            cur_arg_reg   <= '0;
            accum_reg     <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            args_rem_reg  <= args_rem_next;
            bytes_rem_reg <= bytes_rem_next;
            cur_arg_reg   <= cur_arg_next;
            accum_reg     <= accum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= step && res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_free && step && res.valid)
        begin
            kind_reg <= res.kind;
            data_reg <= res.data;
            arg_reg  <= res.arg;
            done_reg <= res.done;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign payload_byte = data_reg;
    assign arg_number   = arg_reg;
    assign request_done = done_reg;

    // Hold the end-of-request flag to end markers only.
    a_done_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> kind_reg == rrd_pkg::KIND_END)
        else $error("request_done on a result that is not an end marker");

    // An error drops the parser into discard with its counters cleared.
    a_err_discard: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.valid && res.kind == rrd_pkg::KIND_ERR
        |=> phase_reg == rrd_pkg::PH_DISCARD && cur_arg_reg == '0 && accum_reg == '0)
        else $error("error result did not enter discard");

    // Payload phase always has bytes still due.
    a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == rrd_pkg::PH_PAYLOAD |-> bytes_rem_reg != '0)
        else $error("payload phase with no bytes remaining");

    // Only payload results carry a byte.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg != rrd_pkg::KIND_DATA |-> data_reg == '0)
        else $error("non-payload result carries a payload byte");

endmodule

>>> tb/tb.sv
// Self-checking testbench for resp_request_deframer_core: a directed table, then random request frames.
// Predicts every result with its own byte-wise parser; depends on rrd_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;

    localparam int ARGS_CAP     = 1024;
    localparam int BULK_LEN_CAP = 536870912;
    localparam int LONG_HOLD    = 300;
    localparam int ITEMS_PER_STAGE = 300;

    // Idle and stall percentages for the four random stages.
    localparam int IDLE_BY_STAGE[4]  = '{0, 64, 0, 37};
    localparam int STALL_BY_STAGE[4] = '{0, 0, 64, 37};

    typedef struct packed {
        logic [rrd_pkg::BYTE_W-1:0] b;
        logic                       pinned;  // expected result typed in below
        rrd_pkg::rrd_result_t       want;
    } stim_row_t;

    // Directed table: idle byte, discarding, leading zeros, payload extremes,
    // zero length, zero count, a '*' that is itself the offending byte, a sign.
    localparam stim_row_t DIRECTED[30] = '{
        '{"A",                1'b1, '{1'b1, rrd_pkg::KIND_ERR,  8'h00, 10'd0, 1'b0}},
        '{"x",                1'b1, '0},
        '{rrd_pkg::CH_STAR,   1'b0, '0},
        '{"0",                1'b0, '0},
        '{"0",                1'b0, '0},
        '{"2",                1'b0, '0},
        '{rrd_pkg::CH_CR,     1'b0, '0},
        '{rrd_pkg::CH_LF,     1'b0, '0},
        '{rrd_pkg::CH_DOLLAR, 1'b0, '0},
        '{"2",                1'b0, '0},
        '{rrd_pkg::CH_CR,     1'b0, '0},
        '{rrd_pkg::CH_LF,     1'b0, '0},
        '{8'hFF,              1'b1, '{1'b1, rrd_pkg::KIND_DATA, 8'hFF, 10'd0, 1'b0}},
        '{8'h00,              1'b1, '{1'b1, rrd_pkg::KIND_DATA, 8'h00, 10'd0, 1'b0}},
        '{rrd_pkg::CH_CR,     1'b0, '0},
        '{rrd_pkg::CH_LF,     1'b1, '{1'b1, rrd_pkg::KIND_END,  8'h00, 10'd0, 1'b0}},
        '{rrd_pkg::CH_DOLLAR, 1'b0, '0},
        '{"0",                1'b0, '0},
        '{rrd_pkg::CH_CR,     1'b0, '0},
        '{rrd_pkg::CH_LF,     1'b0, '0},
        '{rrd_pkg::CH_CR,     1'b0, '0},
        '{rrd_pkg::CH_LF,     1'b1, '{1'b1, rrd_pkg::KIND_END,  8'h00, 10'd1, 1'b1}},
        '{rrd_pkg::CH_STAR,   1'b0, '0},
        '{"0",                1'b0, '0},
        '{rrd_pkg::CH_CR,     1'b1, '{1'b1, rrd_pkg::KIND_ERR,  8'h00, 10'd0, 1'b0}},
        '{rrd_pkg::CH_STAR,   1'b0, '0},
        '{rrd_pkg::CH_STAR,   1'b1, '{1'b1, rrd_pkg::KIND_ERR,  8'h00, 10'd0, 1'b0}},
        '{"1",                1'b1, '0},
        '{rrd_pkg::CH_STAR,   1'b0, '0},
        '{"-",                1'b1, '{1'b1, rrd_pkg::KIND_ERR,  8'h00, 10'd0, 1'b0}}
    };

    logic                          clk;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [rrd_pkg::BYTE_W-1:0]    in_byte   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [rrd_pkg::KIND_W-1:0]    kind;
    logic [rrd_pkg::BYTE_W-1:0]    payload_byte;
    logic [rrd_pkg::ARG_NUM_W-1:0] arg_number;
    logic                          request_done;

    // Parser mirror: the state the block should hold after each accepted transaction.
    rrd_pkg::phase_t parse_phase = rrd_pkg::PH_EXPECT_STAR;
    logic [10:0]     args_left   = '0;
    logic [29:0]     bytes_left  = '0;
    logic [9:0]      arg_idx     = '0;
    logic [29:0]     accum       = '0;

    rrd_pkg::rrd_result_t       expected_results[$];
    logic [rrd_pkg::BYTE_W-1:0] frame_bytes[$];

    int idle_pct      = 0;
    int stall_pct     = 0;
    int fail_count    = 0;
    int items_sent    = 0;
    int hold_requests = 0;
    int hold_seen     = 0;
    int hold_left     = 0;

    resp_request_deframer_core #(
        .MAX_ARGS     (ARGS_CAP),
        .MAX_BULK_LEN (BULK_LEN_CAP)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .kind         (kind),
        .payload_byte (payload_byte),
        .arg_number   (arg_number),
        .request_done (request_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up well beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Report the error at the argument reached, then drop the request.
    task automatic flag_error(output rrd_pkg::rrd_result_t r);
        r = '{1'b1, rrd_pkg::KIND_ERR, 8'h00, arg_idx, 1'b0};
        parse_phase = rrd_pkg::PH_DISCARD;
        args_left   = '0;
        bytes_left  = '0;
        arg_idx     = '0;
        accum       = '0;
    endtask

    task automatic open_request();
        parse_phase = rrd_pkg::PH_COUNT_FIRST;
        args_left   = '0;
        bytes_left  = '0;
        arg_idx     = '0;
        accum       = '0;
    endtask

    // Advance the parser mirror by one byte; r.valid marks a result.
    task automatic parse_byte(input logic [rrd_pkg::BYTE_W-1:0] b,
                              output rrd_pkg::rrd_result_t r);
        logic [63:0] next_val;
        logic        digit;
        logic        last;
        r        = '0;
        digit    = (b >= rrd_pkg::CH_ZERO) && (b <= rrd_pkg::CH_NINE);
        next_val = 64'(accum) * 64'd10 + 64'(b - rrd_pkg::CH_ZERO);
        case (parse_phase)
            rrd_pkg::PH_EXPECT_STAR:
                if (b == rrd_pkg::CH_STAR) open_request();
                else flag_error(r);
            rrd_pkg::PH_COUNT_FIRST:
                if (digit && next_val <= 64'(ARGS_CAP))
                begin
                    accum       = next_val[29:0];
                    parse_phase = rrd_pkg::PH_COUNT_MORE;
                end
                else flag_error(r);
            rrd_pkg::PH_COUNT_MORE:
                if (digit)
                begin
                    if (next_val <= 64'(ARGS_CAP)) accum = next_val[29:0];
                    else flag_error(r);
                end
                else if (b == rrd_pkg::CH_CR && accum != 0)
                    parse_phase = rrd_pkg::PH_COUNT_LF;
                else flag_error(r);
            rrd_pkg::PH_COUNT_LF:
                if (b == rrd_pkg::CH_LF)
                begin
                    args_left   = accum[10:0];
                    arg_idx     = '0;
                    parse_phase = rrd_pkg::PH_EXPECT_DOLLAR;
                end
                else flag_error(r);
            rrd_pkg::PH_EXPECT_DOLLAR:
                if (b == rrd_pkg::CH_DOLLAR)
                begin
                    accum       = '0;
                    parse_phase = rrd_pkg::PH_LEN_FIRST;
                end
                else flag_error(r);
            rrd_pkg::PH_LEN_FIRST:
                if (digit && next_val <= 64'(BULK_LEN_CAP))
                begin
                    accum       = next_val[29:0];
                    parse_phase = rrd_pkg::PH_LEN_MORE;
                end
                else flag_error(r);
            rrd_pkg::PH_LEN_MORE:
                if (digit)
                begin
                    if (next_val <= 64'(BULK_LEN_CAP)) accum = next_val[29:0];
                    else flag_error(r);
                end
                else if (b == rrd_pkg::CH_CR) parse_phase = rrd_pkg::PH_LEN_LF;
                else flag_error(r);
            rrd_pkg::PH_LEN_LF:
                if (b == rrd_pkg::CH_LF)
                begin
                    bytes_left  = accum;
                    parse_phase = (accum == 0) ? rrd_pkg::PH_DATA_CR : rrd_pkg::PH_PAYLOAD;
                end
                else flag_error(r);
            rrd_pkg::PH_PAYLOAD:
            begin
                if (bytes_left != 0) bytes_left = bytes_left - 30'd1;
                if (bytes_left == 0) parse_phase = rrd_pkg::PH_DATA_CR;
                r = '{1'b1, rrd_pkg::KIND_DATA, b, arg_idx, 1'b0};
            end
            rrd_pkg::PH_DATA_CR:
                if (b == rrd_pkg::CH_CR) parse_phase = rrd_pkg::PH_DATA_LF;
                else flag_error(r);
            rrd_pkg::PH_DATA_LF:
                if (b == rrd_pkg::CH_LF)
                begin
                    last = (args_left <= 1);
                    r    = '{1'b1, rrd_pkg::KIND_END, 8'h00, arg_idx, last};
                    if (last)
                    begin
                        args_left   = '0;
                        arg_idx     = '0;
                        parse_phase = rrd_pkg::PH_EXPECT_STAR;
                    end
                    else
                    begin
                        args_left   = args_left - 11'd1;
                        arg_idx     = arg_idx + 10'd1;
                        parse_phase = rrd_pkg::PH_EXPECT_DOLLAR;
                    end
                end
                else flag_error(r);
            default:
                if (b == rrd_pkg::CH_STAR) open_request();
        endcase
    endtask

    // Offer one byte, with random idle cycles first, and hold it until it is taken.
    task automatic send_byte(input logic [rrd_pkg::BYTE_W-1:0] b, input logic pinned,
                             input rrd_pkg::rrd_result_t pin);
        rrd_pkg::rrd_result_t got;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        parse_byte(b, got);
        if (pinned) got = pin;
        if (got.valid) expected_results.insert(expected_results.size(), got);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, '0);
    endtask

    // Feed filler bytes until the parser will take a '*' as a new request.
    task automatic settle_parser();
        while (parse_phase != rrd_pkg::PH_DISCARD && parse_phase != rrd_pkg::PH_EXPECT_STAR)
            send_byte("!", 1'b0, '0);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    task automatic add_byte(input logic [rrd_pkg::BYTE_W-1:0] v);
        frame_bytes.insert(frame_bytes.size(), v);
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endtask

    task automatic push_line(input string s);
        push_text(s);
        add_byte(rrd_pkg::CH_CR);
        add_byte(rrd_pkg::CH_LF);
    endtask

    // Decimal field, now and then with leading zeros.
    task automatic push_decimal(input int unsigned v);
        if ($urandom_range(7) == 0)
            repeat ($urandom_range(1, 3)) add_byte(rrd_pkg::CH_ZERO);
        push_line($sformatf("%0d", v));
    endtask

    // Mostly well-formed requests with random content; some with one byte
    // corrupted, some malformed on purpose, some plain noise.
    task automatic build_request();
        int unsigned pick;
        int unsigned nargs;
        int unsigned len;
        frame_bytes.delete();
        pick = $urandom_range(99);
        if (pick < 85)
        begin
            nargs = ($urandom_range(9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            add_byte(rrd_pkg::CH_STAR);
            push_decimal(nargs);
            repeat (nargs)
            begin
                len = ($urandom_range(7) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
                add_byte(rrd_pkg::CH_DOLLAR);
                push_decimal(len);
                repeat (len) add_byte(8'($urandom_range(255)));
                push_line("");
            end
            if (pick >= 70)
                frame_bytes[$urandom_range(frame_bytes.size() - 1)] = 8'($urandom_range(255));
        end
        else if (pick < 95)
        begin
            case ($urandom_range(7))
                0: push_line("*1025");
                1: push_line("*99999");
                2: push_text("*1024X");
                3: push_line("*0");
                4: push_line("*-1");
                5: begin push_line("*1"); push_line("$536870913"); end
                6: begin push_line("*1"); push_line("$536870912?"); end
                default: begin push_line("*2"); push_line("$"); end
            endcase
        end
        else
            repeat ($urandom_range(1, 6)) add_byte(8'($urandom_range(255)));
    endtask

    // Receiver: random stall, or a long hold-off when the stimulus asks for one.
    always @(posedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen <= hold_requests;
            hold_left <= LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Check every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        rrd_pkg::rrd_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result: kind %0d byte %0h arg %0d done %0b",
                       kind, payload_byte, arg_number, request_done);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    fail_count++;
                end
                if (payload_byte !== want.data)
                begin
                    $error("payload_byte: expected %0h, got %0h", want.data, payload_byte);
                    fail_count++;
                end
                if (arg_number !== want.arg)
                begin
                    $error("arg_number: expected %0d, got %0d", want.arg, arg_number);
                    fail_count++;
                end
                if (request_done !== want.done)
                begin
                    $error("request_done: expected %0b, got %0b", want.done, request_done);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, no idling on either side.
        foreach (DIRECTED[row]) send_byte(DIRECTED[row].b, DIRECTED[row].pinned,
                                          DIRECTED[row].want);

        for (int stage = 0; stage < 4; stage++)
        begin
            idle_pct   = IDLE_BY_STAGE[stage];
            stall_pct  = STALL_BY_STAGE[stage];
            items_sent = 0;
            while (items_sent < ITEMS_PER_STAGE)
            begin
                build_request();
                send_frame();
            end

            if (stage == 0)
            begin
                // Hold off the receiver while a long payload streams in, so the
                // block fills up and stalls its input.
                settle_parser();
                hold_requests++;
                frame_bytes.delete();
                push_line("*1");
                push_line("$64");
                repeat (64) add_byte(8'($urandom_range(255)));
                push_line("");
                send_frame();

                // Pause the sender until every result is out.
                drain_results();

                // Largest legal count: accepted, then a bad separator ends it.
                frame_bytes.delete();
                push_line("*1024");
                push_line("$1");
                push_line("z");
                push_text("X");
                send_frame();
            end
        end

        stall_pct = 0;
        drain_results();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
